### rtl/assert_macros.svh
//------------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the RTL.
//------------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ccrc_pkg.sv
//------------------------------------------------------------------------------
// ccrc_pkg
// Constants and the byte fold function of the reflected CRC-32.
//------------------------------------------------------------------------------
package ccrc_pkg;

  localparam int unsigned CrcWidth  = 32;
  localparam int unsigned ByteWidth = 8;

  localparam logic [CrcWidth-1:0] CrcPolyRefl = 32'hEDB8_8320;
  localparam logic [CrcWidth-1:0] CrcAllOnes  = 32'hFFFF_FFFF;

  typedef logic [CrcWidth-1:0]  crc_t;
  typedef logic [ByteWidth-1:0] byte_t;

  // Fold one byte into a reflected accumulator, LSB first.
  function automatic crc_t crc_fold_byte(crc_t acc, byte_t data);
    crc_t r;
    r = acc ^ {{(CrcWidth-ByteWidth){1'b0}}, data};
    for (int k = 0; k < ByteWidth; k++) begin
      if (r[0]) begin
        r = (r >> 1) ^ CrcPolyRefl;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

endpackage

### rtl/ccrc_intf.sv
//------------------------------------------------------------------------------
// ccrc_intf
// Valid/ready channels for the byte stream and the checksum results.
//------------------------------------------------------------------------------
interface ccrc_byte_if;
  logic                 valid;
  logic                 ready;
  ccrc_pkg::byte_t      data_byte;
  logic                 chunk_end;
  logic                 file_end;

  modport source (output valid, data_byte, chunk_end, file_end, input ready);
  modport sink   (input valid, data_byte, chunk_end, file_end, output ready);
endinterface

interface ccrc_result_if;
  logic                 valid;
  logic                 ready;
  ccrc_pkg::crc_t       chunk_checksum;
  ccrc_pkg::crc_t       file_checksum;
  logic                 file_done;

  modport source (output valid, chunk_checksum, file_checksum, file_done, input ready);
  modport sink   (input valid, chunk_checksum, file_checksum, file_done, output ready);
endinterface

### rtl/chunked_dual_crc32_unit.sv
//------------------------------------------------------------------------------
// chunked_dual_crc32_unit
// Per-chunk and whole-file reflected CRC-32 over a byte stream.
//------------------------------------------------------------------------------
// A result is loaded into the result register when its last byte's beat is
//   committed from the input register, once the output slot is free.
// Throughput: 1 byte per cycle, set by the single input register feeding the
//   one-byte fold into both accumulators, while no chunk-ending byte stalls.
// A result waiting at the output does not stop the input register from taking
//   a byte that ends no chunk; a chunk-ending byte waits for the output slot.
// Reset clears the valid flags and loads both accumulators with all ones.
`include "assert_macros.svh"

module chunked_dual_crc32_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  ccrc_byte_if.sink            data_i,
  ccrc_result_if.source        result_o
);

  // Input register: holds one accepted beat until its fold is committed.
  logic                 in_vld_q;
  ccrc_pkg::byte_t      in_byte_q;
  logic                 in_chunk_end_q;
  logic                 in_file_end_q;

  // Running accumulators.
  ccrc_pkg::crc_t       chunk_acc_q, chunk_acc_d;
  ccrc_pkg::crc_t       file_acc_q, file_acc_d;

  // Result register.
  logic                 out_vld_q;
  ccrc_pkg::crc_t       out_chunk_q;
  ccrc_pkg::crc_t       out_file_q;
  logic                 out_done_q;

  ccrc_pkg::crc_t       chunk_fold;
  ccrc_pkg::crc_t       file_fold;
  logic                 ends_chunk;
  logic                 ends_file;
  logic                 out_free;
  logic                 stage_fire;
  logic                 in_fire;

  // Fold the held byte into both accumulators.
  assign chunk_fold = ccrc_pkg::crc_fold_byte(chunk_acc_q, in_byte_q);
  assign file_fold  = ccrc_pkg::crc_fold_byte(file_acc_q, in_byte_q);

  // A file end closes the chunk as well.
  assign ends_file  = in_file_end_q;
  assign ends_chunk = in_chunk_end_q | in_file_end_q;

  // The output slot is free when empty or being drained this cycle.
  assign out_free   = !out_vld_q || result_o.ready;

  // Commit the held beat unless it needs the output slot and that is busy.
  assign stage_fire = in_vld_q && (!ends_chunk || out_free);

  // Take a new beat when the input register is empty or moving on.
  assign data_i.ready = !in_vld_q || stage_fire;
  assign in_fire      = data_i.valid && data_i.ready;

  // Next accumulator values: fold, then reload on chunk or file end.
  always_comb begin
    chunk_acc_d = chunk_acc_q;
    file_acc_d  = file_acc_q;
    if (stage_fire) begin
      chunk_acc_d = ends_chunk ? ccrc_pkg::CrcAllOnes : chunk_fold;
      file_acc_d  = ends_file  ? ccrc_pkg::CrcAllOnes : file_fold;
    end
  end

  // Control and accumulators.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      chunk_acc_q <= ccrc_pkg::CrcAllOnes;
      file_acc_q  <= ccrc_pkg::CrcAllOnes;
    end else begin
      chunk_acc_q <= chunk_acc_d;
      file_acc_q  <= file_acc_d;
      // Hold the input register while its beat is stalled.
      if (in_fire) begin
        in_vld_q <= 1'b1;
      end else if (stage_fire) begin
        in_vld_q <= 1'b0;
      end
      // Load a result, or drop the one just taken.
      if (stage_fire && ends_chunk) begin
        out_vld_q <= 1'b1;
      end else if (result_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_byte_q      <= data_i.data_byte;
      in_chunk_end_q <= data_i.chunk_end;
      in_file_end_q  <= data_i.file_end;
    end
    if (stage_fire && ends_chunk) begin
      out_chunk_q <= chunk_fold ^ ccrc_pkg::CrcAllOnes;
      out_file_q  <= ends_file ? (file_fold ^ ccrc_pkg::CrcAllOnes) : '0;
      out_done_q  <= ends_file;
    end
  end

  assign result_o.valid          = out_vld_q;
  assign result_o.chunk_checksum = out_chunk_q;
  assign result_o.file_checksum  = out_file_q;
  assign result_o.file_done      = out_done_q;

  // A chunk end must leave the chunk accumulator reloaded.
  `ASSERT_NEXT(a_chunk_reload, clk_i, rst_ni, stage_fire && ends_chunk,
               chunk_acc_q == ccrc_pkg::CrcAllOnes, "chunk accumulator not reloaded")
  // A file end must leave the file accumulator reloaded.
  `ASSERT_NEXT(a_file_reload, clk_i, rst_ni, stage_fire && ends_file,
               file_acc_q == ccrc_pkg::CrcAllOnes, "file accumulator not reloaded")
  // A result that does not close the file carries a zero file checksum.
  `ASSERT_IMPL(a_file_zero, clk_i, rst_ni, out_vld_q && !out_done_q,
               out_file_q == '0, "file checksum set without file end")
  // A new result shows up only after a chunk-ending beat was committed.
  `ASSERT_IMPL(a_out_source, clk_i, rst_ni, $rose(out_vld_q),
               $past(stage_fire) && $past(ends_chunk), "result without chunk end")

endmodule

### tb/sv/tb_top.sv
//------------------------------------------------------------------------------
// tb_top
// Self-checking bench for chunked_dual_crc32_unit. A byte stream is driven with
// random gaps. Each chunk and file checksum coming out of the block is compared
// with a bit-serial CRC-32 kept alongside the stream.
//------------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // One checksum beat as it should leave the block.
  typedef struct packed {
    ccrc_pkg::crc_t chunk_checksum;
    ccrc_pkg::crc_t file_checksum;
    logic           file_done;
  } crc_result_t;

  // Keep the running chunk and file CRCs and a queue of checksums still owed.
  class crc_scoreboard;
    ccrc_pkg::crc_t chunk_run;
    ccrc_pkg::crc_t file_run;
    crc_result_t    owed_sums[$];
    int unsigned    mismatches;
    int unsigned    bytes_seen;
    int unsigned    chunks_closed;
    int unsigned    files_closed;

    function new();
      chunk_run     = ccrc_pkg::CrcAllOnes;
      file_run      = ccrc_pkg::CrcAllOnes;
      mismatches    = 0;
      bytes_seen    = 0;
      chunks_closed = 0;
      files_closed  = 0;
    endfunction

    // Shift one byte in, one bit at a time, LSB first.
    function ccrc_pkg::crc_t crc_shift_byte(ccrc_pkg::crc_t acc, ccrc_pkg::byte_t b);
      logic fb;
      for (int i = 0; i < ccrc_pkg::ByteWidth; i++) begin
        fb  = acc[0] ^ b[i];
        acc = acc >> 1;
        if (fb) begin
          acc = acc ^ ccrc_pkg::CrcPolyRefl;
        end
      end
      return acc;
    endfunction

    // Fold an accepted byte in; queue a checksum if it closes a chunk or file.
    function void note_byte(ccrc_pkg::byte_t b, logic ends_chunk, logic ends_file);
      crc_result_t sum;
      bytes_seen++;
      chunk_run = crc_shift_byte(chunk_run, b);
      file_run  = crc_shift_byte(file_run, b);
      if (ends_chunk || ends_file) begin
        sum.chunk_checksum = chunk_run ^ ccrc_pkg::CrcAllOnes;
        sum.file_checksum  = ends_file ? (file_run ^ ccrc_pkg::CrcAllOnes) : '0;
        sum.file_done      = ends_file;
        chunk_run          = ccrc_pkg::CrcAllOnes;
        if (ends_file) begin
          file_run = ccrc_pkg::CrcAllOnes;
        end
        owed_sums.push_back(sum);
      end
    endfunction

    // Compare an accepted checksum beat with the oldest one owed.
    function void check_result(ccrc_pkg::crc_t chunk_sum, ccrc_pkg::crc_t file_sum,
                               logic done);
      crc_result_t want;
      if (owed_sums.size() == 0) begin
        $error("unexpected result: chunk_checksum %h file_checksum %h file_done %b",
               chunk_sum, file_sum, done);
        mismatches++;
        return;
      end
      want = owed_sums.pop_front();
      chunks_closed++;
      if (want.file_done) begin
        files_closed++;
      end
      if (chunk_sum !== want.chunk_checksum) begin
        $error("chunk_checksum: expected %h, got %h", want.chunk_checksum, chunk_sum);
        mismatches++;
      end
      if (file_sum !== want.file_checksum) begin
        $error("file_checksum: expected %h, got %h", want.file_checksum, file_sum);
        mismatches++;
      end
      if (done !== want.file_done) begin
        $error("file_done: expected %b, got %b", want.file_done, done);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return owed_sums.size();
    endfunction
  endclass

  localparam int unsigned TargetBytes = 1700;
  localparam int unsigned QuietAfter  = 1450;  // drop all idling past this many bytes
  localparam int unsigned DrainLimit  = 4000;

  logic clk_i;
  logic rst_ni;

  ccrc_byte_if   byte_ch ();
  ccrc_result_if sum_ch ();

  chunked_dual_crc32_unit dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .data_i   (byte_ch),
    .result_o (sum_ch)
  );

  crc_scoreboard sb = new();

  bit          quiet;          // set near the end: no gaps, no stalls
  bit          sender_choppy;  // sender inserts gaps while set
  int unsigned bytes_sent;

  // 12 ns clock.
  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Watchdog: far beyond the slowest legal run (every byte after a full gap,
  // every checksum after a full stall).
  initial begin
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end

  // Result side: check each beat, then pick ready for the next edge. Stalls
  // come in bursts, with calm stretches in between.
  initial begin
    int unsigned stall_left;
    bit          receiver_choppy;
    stall_left      = 0;
    receiver_choppy = 1'b1;
    sum_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (sum_ch.valid && sum_ch.ready) begin
        sb.check_result(sum_ch.chunk_checksum, sum_ch.file_checksum, sum_ch.file_done);
      end
      if ($urandom_range(0, 199) == 0) begin
        receiver_choppy = !receiver_choppy;
      end
      if (quiet) begin
        stall_left = 0;
        sum_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        sum_ch.ready <= 1'b0;
      end else if (receiver_choppy && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 14);  // this edge counts as the first
        sum_ch.ready <= 1'b0;
      end else begin
        sum_ch.ready <= 1'b1;
      end
    end
  end

  // Drive one byte beat. Call at a rising edge; return at the accepting edge
  // with valid still high so back-to-back beats need no extra drive.
  task automatic send_byte(input ccrc_pkg::byte_t b, input logic ends_chunk,
                           input logic ends_file);
    int unsigned gap;
    gap = 0;
    if (!quiet && sender_choppy && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 15);
    end
    if (gap > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    byte_ch.valid     <= 1'b1;
    byte_ch.data_byte <= b;
    byte_ch.chunk_end <= ends_chunk;
    byte_ch.file_end  <= ends_file;
    do begin
      @(posedge clk_i);
    end while (!byte_ch.ready);
    sb.note_byte(b, ends_chunk, ends_file);
    bytes_sent++;
  endtask

  // Hold the stream off until every owed checksum has come back.
  task automatic hold_until_drained();
    if (sb.pending() != 0) begin
      byte_ch.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clk_i);
    end
  endtask

  // One well-formed file: a few chunks, mostly short, now and then longer.
  // On the closing byte the chunk flag is random, since file end implies it.
  task automatic send_file();
    int unsigned n_chunks;
    int unsigned len;
    logic        last_chunk;
    n_chunks = $urandom_range(1, 4);
    for (int c = 0; c < n_chunks; c++) begin
      last_chunk = (c == n_chunks - 1);
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
      for (int i = 0; i < len; i++) begin
        if (i == len - 1) begin
          if (last_chunk) begin
            send_byte(ccrc_pkg::byte_t'($urandom), logic'($urandom_range(0, 1)), 1'b1);
          end else begin
            send_byte(ccrc_pkg::byte_t'($urandom), 1'b1, 1'b0);
          end
        end else begin
          send_byte(ccrc_pkg::byte_t'($urandom), 1'b0, 1'b0);
        end
      end
    end
  endtask

  // Noise: raw bytes with random, sparse flags.
  task automatic send_noise();
    int unsigned len;
    len = $urandom_range(1, 24);
    for (int i = 0; i < len; i++) begin
      send_byte(ccrc_pkg::byte_t'($urandom), logic'($urandom_range(0, 7) == 0),
                logic'($urandom_range(0, 15) == 0));
    end
  endtask

  initial begin
    ccrc_pkg::byte_t check_str [9];
    bit              mid_hold_done;
    int unsigned     drain_cycles;

    check_str     = '{8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39};
    quiet         = 1'b0;
    sender_choppy = 1'b1;
    bytes_sent    = 0;
    mid_hold_done = 1'b0;

    // Hold every input at a known value through reset.
    rst_ni            <= 1'b0;
    byte_ch.valid     <= 1'b0;
    byte_ch.data_byte <= '0;
    byte_ch.chunk_end <= 1'b0;
    byte_ch.file_end  <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed part.
    // One-byte file with both flags set.
    send_byte(8'h00, 1'b1, 1'b1);
    // All-ones byte closing a chunk only, then file end without chunk end.
    send_byte(8'hFF, 1'b1, 1'b0);
    send_byte(8'h80, 1'b0, 1'b1);
    // Standard check string: file CRC must come out as CBF43926. Split it
    // into two chunks so the chunk reload is seen mid-file.
    foreach (check_str[i]) begin
      send_byte(check_str[i], logic'(i == 3), logic'(i == 8));
    end
    // Ordinary bytes at the edges of the range, then a chunk end and a file
    // end with both flags.
    send_byte(8'h01, 1'b0, 1'b0);
    send_byte(8'h7F, 1'b0, 1'b0);
    send_byte(8'hFE, 1'b0, 1'b0);
    send_byte(8'h55, 1'b1, 1'b0);
    send_byte(8'hAA, 1'b1, 1'b1);
    hold_until_drained();

    // Random part: mostly well-formed files, some noise.
    while (bytes_sent < TargetBytes) begin
      if (bytes_sent >= QuietAfter) begin
        quiet = 1'b1;
      end
      if (!mid_hold_done && bytes_sent >= TargetBytes / 2) begin
        hold_until_drained();
        mid_hold_done = 1'b1;
      end
      if ($urandom_range(0, 3) == 0) begin
        sender_choppy = !sender_choppy;
      end
      if ($urandom_range(0, 7) == 0) begin
        send_noise();
      end else begin
        send_file();
      end
    end
    // Close any file the noise left open.
    send_byte(ccrc_pkg::byte_t'($urandom), 1'b1, 1'b1);
    byte_ch.valid <= 1'b0;

    // Drain, then give the input and result registers a few extra edges to misbehave.
    drain_cycles = 0;
    while (sb.pending() != 0 && drain_cycles < DrainLimit) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    repeat (8) @(posedge clk_i);
    if (sb.pending() != 0) begin
      $error("%0d checksum results never arrived", sb.pending());
      sb.mismatches++;
    end

    $display("Run covered %0d bytes, %0d chunk checksums and %0d file checksums,",
             sb.bytes_seen, sb.chunks_closed, sb.files_closed);
    $display("with random gaps and output stalls, then a final stretch at full rate.");
    if (sb.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/ccrc_pkg.sv
rtl/ccrc_intf.sv
rtl/chunked_dual_crc32_unit.sv
tb/sv/tb_top.sv
